// ===== sv/mmat_pkg.sv =====
// Shared types, constants and helpers for the multichannel moving average block.
`default_nettype none

package mmat_pkg;

   localparam int NUM_CHANNELS_DEF = 11;
   localparam int WINDOW_DEF       = 5;
   localparam int CHAN_W           = 4;
   localparam int PRICE_W          = 24;

   typedef enum logic [1:0] {
      TREND_FLAT = 2'd0,
      TREND_RISE = 2'd1,
      TREND_FALL = 2'd2
   } trend_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  channel;
      logic [PRICE_W-1:0] price;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  out_channel;
      logic [PRICE_W-1:0] average;
      trend_type          price_trend;
      trend_type          average_trend;
   } rsp_type;

   function automatic trend_type trend_of(input logic [PRICE_W-1:0] now,
                                          input logic [PRICE_W-1:0] prev);
      trend_type t;
      if (now > prev) begin
         t = TREND_RISE;
      end else if (now < prev) begin
         t = TREND_FALL;
      end else begin
         t = TREND_FLAT;
      end
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== sv/mmat_div.sv =====
// Divide of the window sum by the sample count through a reciprocal table and one multiply.
`default_nettype none

module mmat_div
   import mmat_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input  wire logic                                        clock,
   input  wire logic                                        mul_en,
   input  wire logic [PRICE_W+((WINDOW > 1) ? $clog2(WINDOW) : 0)-1:0] sum_i,
   input  wire logic [$clog2(WINDOW+1)-1:0]                 count_i,
   output logic      [PRICE_W-1:0]                          quot_o
);

   localparam int L_W   = (WINDOW > 1) ? $clog2(WINDOW) : 0;
   localparam int SUM_W = PRICE_W + L_W;
   localparam int M_W   = SUM_W + L_W + 1;
   localparam int P_W   = SUM_W + M_W;
   localparam int SHIFT = SUM_W + L_W;

   // m = ceil(2^SHIFT / d): floor(x*m >> SHIFT) is exact for every x below 2^SUM_W
   logic [M_W-1:0] recip [WINDOW+1];
   logic [P_W-1:0] prod_ff;
   logic [P_W-1:0] prod_in;

   assign recip[0] = '0;

   for (genvar d = 1; d <= WINDOW; d++) begin : g_recip
      localparam logic [63:0] MV = ((64'd1 << SHIFT) + 64'(d) - 64'd1) / 64'(d);
      assign recip[d] = MV[M_W-1:0];
   end

   assign prod_in = P_W'(sum_i) * P_W'(recip[count_i]);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign quot_o = PRICE_W'(prod_ff >> SHIFT);

endmodule

`default_nettype wire

// ===== sv/multichannel_moving_average_trend.sv =====
// Top level: per-channel moving average with price and average trend flags.
//
//   port group  dir  handshake             word
//   req_        in   req_valid/req_stall   req_type: channel, price
//   rsp_        out  rsp_valid/rsp_stall   rsp_type: out_channel, average, trends
//
// A sample passes four steps: memory read, sum update, reciprocal multiply, writeback.
// The next sample is taken once the previous result sits in the output register.
// Channel state lives in two memories with registered reads; per-channel valid flags stand for
// the zeroed state after reset, so there is no clearing pass.
// Samples for channels out of range are taken and dropped without a result.
`default_nettype none

module multichannel_moving_average_trend
   import mmat_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int WINDOW       = WINDOW_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int L_W      = (WINDOW > 1) ? $clog2(WINDOW) : 0;
   localparam int SUM_W    = PRICE_W + L_W;
   localparam int CNT_W    = $clog2(WINDOW+1);
   localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CHX_W    = (CH_IDX_W > CHAN_W) ? CH_IDX_W : CHAN_W;

   typedef struct packed {
      logic [CNT_W-1:0]   count;
      logic [SLOT_W-1:0]  slot;
      logic [SUM_W-1:0]   sum;
      logic [PRICE_W-1:0] last_price;
      logic [PRICE_W-1:0] last_avg;
   } rec_type;

   typedef logic [WINDOW-1:0][PRICE_W-1:0] row_type;

   rec_type   rec_mem  [NUM_CHANNELS];
   row_type   hist_mem [NUM_CHANNELS];

   state_type state_ff, state_in;
   logic [NUM_CHANNELS-1:0] rec_vld_ff;
   rec_type   rec_rd_ff;
   logic      vld_rd_ff;
   row_type   row_rd_ff;
   req_type   req_ff;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;

   logic [CHX_W-1:0]    ch_wide;
   logic [CHX_W-1:0]    chq_wide;
   logic [CH_IDX_W-1:0] idx_new;
   logic [CH_IDX_W-1:0] idx_q;
   logic                in_range;
   logic                req_acc;
   logic                go;
   logic                sum_en, mul_en, fin_en, out_free;
   rec_type             rec_cur;
   rec_type             rec_wr;
   logic [SLOT_W-1:0]   slot_use;
   logic [PRICE_W-1:0]  old_price;
   logic                full;
   row_type             row_new;
   logic [PRICE_W-1:0]  quot;

   assign ch_wide  = CHX_W'(req_data.channel);
   assign chq_wide = CHX_W'(req_ff.channel);
   assign idx_new  = ch_wide[CH_IDX_W-1:0];
   assign idx_q    = chq_wide[CH_IDX_W-1:0];
   assign in_range = ch_wide < CHX_W'(NUM_CHANNELS);
   assign req_acc  = req_valid && !req_stall;
   assign go       = req_acc && in_range;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (go) state_in = ST_SUM;
         ST_SUM:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_FIN;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      sum_en    = 1'b0;
      mul_en    = 1'b0;
      fin_en    = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_SUM:  sum_en = 1'b1;
         ST_MUL:  mul_en = 1'b1;
         ST_FIN:  fin_en = out_free;
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // memory reads on accept
   always_ff @(posedge clock) begin
      if (go) begin
         rec_rd_ff <= rec_mem[idx_new];
         row_rd_ff <= hist_mem[idx_new];
         vld_rd_ff <= rec_vld_ff[idx_new];
         req_ff    <= req_data;
      end
   end

   // the record of a never-written channel reads as all zero
   assign rec_cur = vld_rd_ff ? rec_rd_ff : '0;

   always_comb begin
      if ({1'b0, rec_cur.slot} >= (SLOT_W+1)'(WINDOW)) begin
         slot_use = '0;
      end else begin
         slot_use = rec_cur.slot;
      end
      full      = rec_cur.count >= CNT_W'(WINDOW);
      old_price = row_rd_ff[slot_use];
      if (full) begin
         sum_in = rec_cur.sum - SUM_W'(old_price) + SUM_W'(req_ff.price);
         cnt_in = rec_cur.count;
      end else begin
         sum_in = rec_cur.sum + SUM_W'(req_ff.price);
         cnt_in = rec_cur.count + CNT_W'(1);
      end
      if (({1'b0, slot_use} + (SLOT_W+1)'(1)) >= (SLOT_W+1)'(WINDOW)) begin
         slot_in = '0;
      end else begin
         slot_in = slot_use + SLOT_W'(1);
      end
      row_new           = row_rd_ff;
      row_new[slot_use] = req_ff.price;
   end

   always_ff @(posedge clock) begin
      if (sum_en) begin
         sum_ff  <= sum_in;
         cnt_ff  <= cnt_in;
         slot_ff <= slot_in;
         hist_mem[idx_q] <= row_new;
      end
   end

   mmat_div #(
      .WINDOW (WINDOW)
   ) u_div (
      .clock   (clock),
      .mul_en  (mul_en),
      .sum_i   (sum_ff),
      .count_i (cnt_ff),
      .quot_o  (quot)
   );

   always_comb begin
      rec_wr.count      = cnt_ff;
      rec_wr.slot       = slot_ff;
      rec_wr.sum        = sum_ff;
      rec_wr.last_price = req_ff.price;
      rec_wr.last_avg   = quot;
   end

   // writeback and result word
   always_ff @(posedge clock) begin
      if (fin_en) begin
         rec_mem[idx_q]            <= rec_wr;
         rsp_ff.out_channel        <= req_ff.channel;
         rsp_ff.average            <= quot;
         rsp_ff.price_trend        <= trend_of(req_ff.price, rec_cur.last_price);
         rsp_ff.average_trend      <= trend_of(quot, rec_cur.last_avg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fin_en) begin
            rec_vld_ff[idx_q] <= 1'b1;
            rsp_valid_ff      <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result word appeared without a writeback");

   a_sum_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> $past(state_ff == ST_IDLE && go))
      else $error("sum stage entered without an accepted sample");

   a_count_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (cnt_ff != '0 && cnt_ff <= CNT_W'(WINDOW)))
      else $error("sample count out of range at divide");

   a_valid_after_wb: assert property (@(posedge clock) disable iff (reset)
      fin_en |=> rec_vld_ff[idx_q])
      else $error("channel record not marked valid after writeback");

endmodule

`default_nettype wire
